@@ rtl/lin_diag_frame_segmenter_assert.svh @@
// Assertion macros used by the segmenter RTL.
// Included by the modules that carry concurrent checks; needs no package.
`ifndef LIN_DIAG_FRAME_SEGMENTER_ASSERT_SVH
`define LIN_DIAG_FRAME_SEGMENTER_ASSERT_SVH
`ifndef SYNTHESIS
`define LDS_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define LDS_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define LDS_ASSERT(label, clk, rst_n, prop, msg)
`define LDS_ASSERT_NEVER(label, clk, rst_n, cond, msg)
`endif
`endif

@@ rtl/lds_pkg.sv @@
// Package of the LIN diagnostic frame segmenter: item types and frame constants.
// Used by lds_front, lds_back and the top level; depends on nothing.
package lds_pkg;

  localparam logic [7:0]  PadByte   = 8'hCC;
  localparam logic [63:0] PadWord   = {8{PadByte}};
  localparam logic [3:0]  PciFirst  = 4'h1;
  localparam logic [3:0]  PciConsec = 4'h2;
  localparam logic [11:0] SingleMax = 12'd6;

  localparam int CmdDepthDefault = 2;
  localparam int ResDepthDefault = 2;

  typedef struct packed {
    logic [7:0]  nad;
    logic [11:0] message_length;
    logic [7:0]  payload_byte;
  } lds_in_t;

  typedef struct packed {
    logic [63:0] frame;
    logic        last_frame;
  } lds_out_t;

  typedef struct packed {
    logic        start;
    logic        single;
    logic        last;
    logic [7:0]  nad;
    logic [11:0] message_length;
    logic [7:0]  payload_byte;
  } lds_cmd_t;

endpackage

@@ rtl/lds_fifo.sv @@
// Small register queue used between the front, the back and the result port.
// Depends on nothing; the item type is given by the instantiating module.
module lds_fifo #(
  parameter int  Depth  = 2,
  parameter type item_t = logic
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t item_i,
  output logic  full_o,
  input  logic  pop_i,
  output item_t item_o,
  output logic  empty_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  item_t           mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == FullCnt);
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign item_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

@@ rtl/lds_front.sv @@
// Front part: accepts input items, tracks the bytes left in the message and
// turns each item, but a zero-length start item, into a command for the frame builder. Depends on lds_pkg.
module lds_front import lds_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  lds_in_t  item_i,
  output logic     full_o,
  output logic     cmd_push_o,
  output lds_cmd_t cmd_o,
  input  logic     cmd_full_i
);

  logic [11:0] bytes_left_q, bytes_left_d;
  logic        accept, idle;

  assign full_o = cmd_full_i;
  assign accept = push_i && !cmd_full_i;
  assign idle   = (bytes_left_q == '0);

  always_comb begin
    bytes_left_d        = bytes_left_q;
    cmd_push_o          = 1'b0;
    cmd_o.start         = idle;
    cmd_o.single        = (item_i.message_length <= SingleMax);
    cmd_o.nad           = item_i.nad;
    cmd_o.message_length = item_i.message_length;
    cmd_o.payload_byte  = item_i.payload_byte;
    cmd_o.last          = idle ? (item_i.message_length == 12'd1)
                               : (bytes_left_q == 12'd1);
    if (accept) begin
      if (idle) begin
        if (item_i.message_length != '0) begin
          cmd_push_o   = 1'b1;
          bytes_left_d = item_i.message_length - 12'd1;
        end
      end else begin
        cmd_push_o   = 1'b1;
        bytes_left_d = bytes_left_q - 12'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bytes_left_q <= '0;
    end else begin
      bytes_left_q <= bytes_left_d;
    end
  end

endmodule

@@ rtl/lds_back.sv @@
// Back part: builds frames one byte per command and hands finished frames on.
// Depends on lds_pkg and the assertion macro header.
`include "lin_diag_frame_segmenter_assert.svh"
module lds_back import lds_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  lds_cmd_t cmd_i,
  input  logic     cmd_valid_i,
  output logic     cmd_pop_o,
  output lds_out_t res_o,
  output logic     res_push_o,
  input  logic     res_full_i
);

  logic [63:0] frame_q, frame_d, base, filled;
  logic [2:0]  slot_q, slot_d, slot;
  logic [3:0]  seq_q, seq_d;
  logic [7:0]  addr_q, addr_d;
  logic        take, emit;

  assign take      = cmd_valid_i && !res_full_i;
  assign cmd_pop_o = take;

  always_comb begin
    base = frame_q;
    slot = slot_q;
    if (cmd_i.start) begin
      base       = PadWord;
      base[7:0]  = cmd_i.nad;
      if (cmd_i.single) begin
        base[15:8] = cmd_i.message_length[7:0];
        slot       = 3'd2;
      end else begin
        base[15:8]  = {PciFirst, cmd_i.message_length[11:8]};
        base[23:16] = cmd_i.message_length[7:0];
        slot        = 3'd3;
      end
    end
    filled = base;
    for (int i = 0; i < 8; i++) begin
      if (slot == 3'(i)) begin
        filled[i*8 +: 8] = cmd_i.payload_byte;
      end
    end
    emit = (slot == 3'd7) || cmd_i.last;

    frame_d = frame_q;
    slot_d  = slot_q;
    seq_d   = seq_q;
    addr_d  = addr_q;
    if (take) begin
      if (cmd_i.start) begin
        addr_d = cmd_i.nad;
        seq_d  = 4'd1;
      end
      if (emit) begin
        frame_d = PadWord;
        if (cmd_i.last) begin
          slot_d = '0;
        end else begin
          frame_d[7:0]  = addr_q;
          frame_d[15:8] = {PciConsec, seq_q};
          seq_d         = seq_q + 4'd1;
          slot_d        = 3'd2;
        end
      end else begin
        frame_d = filled;
        slot_d  = slot + 3'd1;
      end
    end
  end

  assign res_push_o       = take && emit;
  assign res_o.frame      = filled;
  assign res_o.last_frame = cmd_i.last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_q <= PadWord;
      slot_q  <= '0;
      seq_q   <= 4'd1;
      addr_q  <= '0;
    end else begin
      frame_q <= frame_d;
      slot_q  <= slot_d;
      seq_q   <= seq_d;
      addr_q  <= addr_d;
    end
  end

  `LDS_ASSERT_NEVER(a_slot_not_one, clk_i, rst_ni, slot_q == 3'd1, "slot one is never open")
  `LDS_ASSERT(a_last_clears, clk_i, rst_ni, (res_push_o && res_o.last_frame) |=> (slot_q == 3'd0 && frame_q == PadWord), "frame not cleared after message end")
  `LDS_ASSERT(a_idle_takes_start, clk_i, rst_ni, (cmd_pop_o && slot_q == 3'd0) |-> cmd_i.start, "idle builder got a continuation item")

endmodule

@@ rtl/lin_diag_frame_segmenter.sv @@
// Top level of the LIN diagnostic frame segmenter.
// Depends on lds_pkg, lds_fifo, lds_front and lds_back.
//
// Takes one payload byte per cycle and emits 8-byte LIN transport frames
// (single, first and consecutive frames, padded with 0xCC). One item is
// accepted every cycle as long as results are taken; the frame builder
// inserts one byte per cycle, which sets that rate. A frame is readable after
// the item that completes it passes the command queue and the builder writes
// the frame into the result queue. A zero-length start item gives no result.
module lin_diag_frame_segmenter import lds_pkg::*; #(
  parameter int CmdDepth = CmdDepthDefault,
  parameter int ResDepth = ResDepthDefault
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push,
  input  lds_in_t  item_i,
  output logic     full,
  output logic     empty,
  input  logic     pop,
  output lds_out_t result_o
);

  lds_cmd_t cmd_in, cmd_out;
  lds_out_t res_in;
  logic     cmd_push, cmd_full, cmd_empty, cmd_pop;
  logic     res_push, res_full;

  lds_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .item_i     (item_i),
    .full_o     (full),
    .cmd_push_o (cmd_push),
    .cmd_o      (cmd_in),
    .cmd_full_i (cmd_full)
  );

  lds_fifo #(.Depth(CmdDepth), .item_t(lds_cmd_t)) u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .item_i  (cmd_in),
    .full_o  (cmd_full),
    .pop_i   (cmd_pop),
    .item_o  (cmd_out),
    .empty_o (cmd_empty)
  );

  lds_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd_out),
    .cmd_valid_i (!cmd_empty),
    .cmd_pop_o   (cmd_pop),
    .res_o       (res_in),
    .res_push_o  (res_push),
    .res_full_i  (res_full)
  );

  lds_fifo #(.Depth(ResDepth), .item_t(lds_out_t)) u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .item_i  (res_in),
    .full_o  (res_full),
    .pop_i   (pop),
    .item_o  (result_o),
    .empty_o (empty)
  );

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// Testbench of lin_diag_frame_segmenter: streams diagnostic messages byte by byte
// and checks every transport frame against a frame builder of its own.
// Depends on lds_pkg and the segmenter RTL.
module tb_top;
  import lds_pkg::*;

  localparam int CycleLimit   = 200000;
  localparam int RandomBytes  = 800;
  localparam int HoldAtFrame  = 40;
  localparam int HoldCycles   = 60;
  localparam int TailCycles   = 12;

  class frame_scoreboard;
    logic [63:0] building;
    logic [2:0]  slot;
    logic [11:0] remaining;
    logic [3:0]  seq_no;
    logic [7:0]  address;
    lds_out_t    frames_due[$];
    int unsigned mismatches;

    function new();
      building   = PadWord;
      slot       = 3'd0;
      remaining  = 12'd0;
      seq_no     = 4'd1;
      address    = 8'd0;
      mismatches = 0;
    endfunction

    function void put_byte(int pos, logic [7:0] value);
      building[8*pos +: 8] = value;
    endfunction

    function void note_item(lds_in_t it);
      lds_out_t frame_out;
      bit       slot_full;
      if (remaining == 12'd0) begin
        if (it.message_length == 12'd0) return;
        address   = it.nad;
        remaining = it.message_length;
        seq_no    = 4'd1;
        building  = PadWord;
        put_byte(0, it.nad);
        if (it.message_length <= SingleMax) begin
          put_byte(1, it.message_length[7:0]);
          slot = 3'd2;
        end else begin
          put_byte(1, {PciFirst, it.message_length[11:8]});
          put_byte(2, it.message_length[7:0]);
          slot = 3'd3;
        end
      end
      put_byte(slot, it.payload_byte);
      slot_full = (slot == 3'd7);
      slot      = slot + 3'd1;
      remaining = remaining - 12'd1;
      if (!slot_full && remaining != 12'd0) return;
      frame_out.frame      = building;
      frame_out.last_frame = (remaining == 12'd0);
      frames_due.push_back(frame_out);
      building = PadWord;
      if (remaining != 12'd0) begin
        put_byte(0, address);
        put_byte(1, {PciConsec, seq_no});
        seq_no = seq_no + 4'd1;
        slot   = 3'd2;
      end else begin
        slot = 3'd0;
      end
    endfunction

    function void check_frame(lds_out_t got);
      lds_out_t want;
      if (frames_due.size() == 0) begin
        $error("unexpected frame %h last_frame %0d", got.frame, got.last_frame);
        mismatches++;
        return;
      end
      want = frames_due.pop_front();
      if (got.frame !== want.frame) begin
        $error("frame: expected %h, actual %h", want.frame, got.frame);
        mismatches++;
      end
      if (got.last_frame !== want.last_frame) begin
        $error("last_frame: expected %0d, actual %0d", want.last_frame, got.last_frame);
        mismatches++;
      end
    endfunction

    function int pending();
      return frames_due.size();
    endfunction
  endclass

  logic     clk_i = 1'b0;
  logic     rst_ni;
  logic     push;
  lds_in_t  item_i;
  logic     full;
  logic     empty;
  logic     pop;
  lds_out_t result_o;

  frame_scoreboard sb = new();
  int unsigned     bytes_sent;
  int unsigned     frames_taken;
  int unsigned     cycle_count;
  bit              hold_done;

  lin_diag_frame_segmenter dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push     (push),
    .item_i   (item_i),
    .full     (full),
    .empty    (empty),
    .pop      (pop),
    .result_o (result_o)
  );

  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CycleLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic send_item(input lds_in_t it);
    bit steady;
    steady = (bytes_sent >= 300 && bytes_sent < 420);
    if (!steady && $urandom_range(0, 99) < 20) begin
      repeat ($urandom_range(1, 4)) begin
        @(negedge clk_i);
        push <= 1'b0;
      end
    end
    @(negedge clk_i);
    push   <= 1'b1;
    item_i <= it;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    sb.note_item(it);
  endtask

  task automatic send_message(input logic [7:0] nad, input logic [11:0] len, input bit extremes);
    lds_in_t it;
    for (int i = 0; i < len; i++) begin
      it.nad            = (i == 0) ? nad : 8'($urandom);
      it.message_length = (i == 0) ? len : 12'($urandom);
      if (extremes) it.payload_byte = i[0] ? 8'hFF : 8'h00;
      else          it.payload_byte = 8'($urandom);
      send_item(it);
      bytes_sent++;
    end
  endtask

  task automatic send_dropped(input logic [7:0] nad);
    lds_in_t it;
    it.nad            = nad;
    it.message_length = 12'd0;
    it.payload_byte   = 8'($urandom);
    send_item(it);
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    push <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  initial begin
    pop = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (frames_taken == HoldAtFrame && !hold_done) begin
        hold_done = 1'b1;
        pop <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
      end else begin
        pop <= (frames_taken >= 80 && frames_taken < 140) || $urandom_range(0, 99) >= 33;
        @(posedge clk_i);
        if (pop && !empty) begin
          sb.check_frame(result_o);
          frames_taken++;
        end
      end
    end
  end

  initial begin
    bit          drained;
    int unsigned roll;
    int unsigned len;
    drained = 1'b0;
    rst_ni  = 1'b0;
    push    = 1'b0;
    item_i  = '0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    send_dropped(8'h55);
    send_message(8'h00, 12'd1, 1'b1);
    send_message(8'hFF, 12'd6, 1'b1);
    send_message(8'hA5, 12'd7, 1'b0);
    send_dropped(8'hFF);
    send_message(8'h3C, 12'd11, 1'b0);

    while (bytes_sent < RandomBytes) begin
      if (!drained && bytes_sent >= 450) begin
        drained = 1'b1;
        wait_drained();
      end
      roll = $urandom_range(0, 99);
      if (roll < 8) begin
        send_dropped(8'($urandom));
      end else begin
        roll = $urandom_range(0, 99);
        if (roll < 60)      len = $urandom_range(1, 20);
        else if (roll < 90) len = $urandom_range(21, 120);
        else                len = $urandom_range(121, 300);
        send_message(8'($urandom), 12'(len), 1'b0);
      end
    end
    send_message(8'($urandom), 12'd101, 1'b0);

    @(negedge clk_i);
    push <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);
    if (sb.mismatches == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule

@@ files.f @@
+incdir+rtl
rtl/lds_pkg.sv
rtl/lds_fifo.sv
rtl/lds_front.sv
rtl/lds_back.sv
rtl/lin_diag_frame_segmenter.sv
tb/tb_top.sv
